// ----- rtl/stwm_pkg.sv -----
// Package with the opcodes, the sequencer state type and the data width of the two-way merge.
package stwm_pkg;

	localparam int unsigned DATA_W = 32;

	localparam logic [1:0] OP_APPEND_FIRST  = 2'd0;
	localparam logic [1:0] OP_APPEND_SECOND = 2'd1;
	localparam logic [1:0] OP_MERGE         = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_EMIT
	} state_t;

endpackage

// ----- rtl/stwm_cmd_if.sv -----
// Command channel: opcode and value beats into the merge block.
interface stwm_cmd_if;
	logic                                  valid;
	logic                                  ready;
	logic [1:0]                            opcode;
	logic signed [stwm_pkg::DATA_W-1:0]    value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink (input valid, input opcode, input value, output ready);
endinterface

// ----- rtl/stwm_res_if.sv -----
// Result channel: merged value beats out of the merge block.
interface stwm_res_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [stwm_pkg::DATA_W-1:0]    merged_value;
	logic                                  from_second;
	logic                                  last;
	logic                                  empty_res;

	modport source (output valid, output merged_value, output from_second, output last,
		output empty_res, input ready);
	modport sink (input valid, input merged_value, input from_second, input last,
		input empty_res, output ready);
endinterface

// ----- rtl/sorted_two_way_merge_top.sv -----
// Top level of the stable two-way merge of two ascending sequences.
//
// The cmd channel carries one command per beat. An append beat writes its value into the
// first or second store and the block stays ready for the next command; an
// append to a full store is dropped. A merge beat starts the sequencer, which walks both
// stores with one signed comparator and sends every stored value on the res channel in
// ascending order, first store first on ties, with last set on the final beat.
// Each result passes the states READ, CMP and EMIT: READ reads the two heads from the
// stores, CMP compares them into the output register and EMIT hands the beat over. A
// merge of two empty stores gives a single beat with empty_res set. While a merge runs,
// cmd.ready is low.
// A stalled receiver holds the output register and the sequencer in place until it takes
// the beat. Both counts are cleared once the last beat is taken.
// Reset clears both counts and returns the sequencer to idle; the store contents are not
// cleared and need no clearing pass.
module sorted_two_way_merge_top #(
	parameter int unsigned DEPTH = 32
) (
	input logic          clk,
	input logic          arst_n,
	stwm_cmd_if.sink     cmd,
	stwm_res_if.source   res
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	stwm_pkg::state_t state_q;
	stwm_pkg::state_t state_d;

	logic signed [stwm_pkg::DATA_W-1:0] first_mem [DEPTH];
	logic signed [stwm_pkg::DATA_W-1:0] second_mem [DEPTH];
	logic signed [stwm_pkg::DATA_W-1:0] first_head_q;
	logic signed [stwm_pkg::DATA_W-1:0] second_head_q;

	logic [CW-1:0] first_cnt_q;
	logic [CW-1:0] second_cnt_q;
	logic [CW-1:0] first_idx_q;
	logic [CW-1:0] second_idx_q;

	logic signed [stwm_pkg::DATA_W-1:0] value_q;
	logic                               from_second_q;
	logic                               last_q;
	logic                               empty_q;

	logic cmd_fire;
	logic res_fire;
	logic is_merge;
	logic both_empty;
	logic first_left;
	logic second_left;
	logic take_first;
	logic wr_first;
	logic wr_second;

	assign cmd_fire    = cmd.valid && cmd.ready;
	assign res_fire    = res.valid && res.ready;
	assign is_merge    = cmd.opcode == stwm_pkg::OP_MERGE;
	assign both_empty  = (first_cnt_q == '0) && (second_cnt_q == '0);
	assign first_left  = first_idx_q < first_cnt_q;
	assign second_left = second_idx_q < second_cnt_q;
	assign wr_first    = cmd_fire && (cmd.opcode == stwm_pkg::OP_APPEND_FIRST)
		&& (first_cnt_q < CW'(DEPTH));
	assign wr_second   = cmd_fire && (cmd.opcode == stwm_pkg::OP_APPEND_SECOND)
		&& (second_cnt_q < CW'(DEPTH));

	always_comb begin
		if (!second_left) begin
			take_first = 1'b1;
		end else if (!first_left) begin
			take_first = 1'b0;
		end else begin
			take_first = first_head_q <= second_head_q;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stwm_pkg::ST_IDLE: begin
				if (cmd_fire && is_merge) begin
					state_d = both_empty ? stwm_pkg::ST_EMIT : stwm_pkg::ST_READ;
				end
			end
			stwm_pkg::ST_READ: begin
				state_d = stwm_pkg::ST_CMP;
			end
			stwm_pkg::ST_CMP: begin
				state_d = stwm_pkg::ST_EMIT;
			end
			stwm_pkg::ST_EMIT: begin
				if (res.ready) begin
					state_d = last_q ? stwm_pkg::ST_IDLE : stwm_pkg::ST_READ;
				end
			end
			default: begin
				state_d = stwm_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.ready = 1'b0;
		res.valid = 1'b0;
		unique case (state_q)
			stwm_pkg::ST_IDLE: cmd.ready = 1'b1;
			stwm_pkg::ST_EMIT: res.valid = 1'b1;
			default: begin
				cmd.ready = 1'b0;
				res.valid = 1'b0;
			end
		endcase
	end

	assign res.merged_value = value_q;
	assign res.from_second  = from_second_q;
	assign res.last         = last_q;
	assign res.empty_res    = empty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stwm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_cnt_q  <= '0;
			second_cnt_q <= '0;
			first_idx_q  <= '0;
			second_idx_q <= '0;
		end else begin
			if (wr_first) begin
				first_cnt_q <= CW'(first_cnt_q + 1'b1);
			end
			if (wr_second) begin
				second_cnt_q <= CW'(second_cnt_q + 1'b1);
			end
			if (cmd_fire && is_merge) begin
				first_idx_q  <= '0;
				second_idx_q <= '0;
			end
			if (state_q == stwm_pkg::ST_CMP) begin
				if (take_first) begin
					first_idx_q <= CW'(first_idx_q + 1'b1);
				end else begin
					second_idx_q <= CW'(second_idx_q + 1'b1);
				end
			end
			if (res_fire && last_q) begin
				first_cnt_q  <= '0;
				second_cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_first) begin
			first_mem[first_cnt_q[AW-1:0]] <= cmd.value;
		end
		if (wr_second) begin
			second_mem[second_cnt_q[AW-1:0]] <= cmd.value;
		end
		first_head_q  <= first_mem[first_idx_q[AW-1:0]];
		second_head_q <= second_mem[second_idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd_fire && is_merge && both_empty) begin
			value_q       <= '0;
			from_second_q <= 1'b0;
			last_q        <= 1'b1;
			empty_q       <= 1'b1;
		end else if (state_q == stwm_pkg::ST_CMP) begin
			value_q       <= take_first ? first_head_q : second_head_q;
			from_second_q <= !take_first;
			last_q        <= take_first
				? ((CW'(first_idx_q + 1'b1) == first_cnt_q) && !second_left)
				: ((CW'(second_idx_q + 1'b1) == second_cnt_q) && !first_left);
			empty_q       <= 1'b0;
		end
	end

endmodule

// ----- rtl/stwm_checker.sv -----
// Port-level checker of the two-way merge and its bind to the top level.
module stwm_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cmd_valid,
	input logic                               cmd_ready,
	input logic [1:0]                         cmd_opcode,
	input logic                               res_valid,
	input logic                               res_ready,
	input logic signed [stwm_pkg::DATA_W-1:0] res_merged_value,
	input logic                               res_last,
	input logic                               res_empty_res
);

	ap_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_ready && res_valid))
		else $error("Command ready while a result beat is pending.");

	ap_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_merged_value) && $stable(res_last))
		else $error("Stalled result beat changed.");

	ap_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_empty_res |-> res_last)
		else $error("Empty result beat without last.");

	ap_merge_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_opcode == stwm_pkg::OP_MERGE) |=> !cmd_ready)
		else $error("Block ready right after a merge command.");

	ap_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && res_last |=> cmd_ready && !res_valid)
		else $error("Block not idle after the last result beat.");

endmodule

bind sorted_two_way_merge_top stwm_checker u_stwm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.cmd_opcode       (cmd.opcode),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_merged_value (res.merged_value),
	.res_last         (res.last),
	.res_empty_res    (res.empty_res)
);
